/* src/mpfb_pkg.sv */
// Shared constants and types for the monochrome page framebuffer blitter.
`default_nettype none

package mpfb_pkg;

  // Screen geometry: pages of eight pixel rows, one byte per column per page.
  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_PAGES   = 8;
  localparam int SCREEN_ROWS    = SCREEN_PAGES * 8;
  localparam int STORE_BYTES    = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int ADDR_W         = $clog2(STORE_BYTES);

  // Configuration port widths and register reset values.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam logic [7:0] BLIT_WIDTH_RST  = 8'd128;
  localparam logic [6:0] BLIT_HEIGHT_RST = 7'd64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_X      = 3'd0,
    CFG_DEST_Y      = 3'd1,
    CFG_BLIT_WIDTH  = 3'd2,
    CFG_BLIT_HEIGHT = 3'd3
  } cfg_index_e;

  // Transaction action codes.
  typedef enum logic [1:0] {
    ACT_BLIT  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b000_0001,
    ST_IDLE  = 7'b000_0010,
    ST_RDW   = 7'b000_0100,
    ST_BRD0  = 7'b000_1000,
    ST_BWR0  = 7'b001_0000,
    ST_BRD1  = 7'b010_0000,
    ST_BWR1  = 7'b100_0000
  } state_e;

endpackage

`default_nettype wire

/* src/mono_page_framebuffer_blitter_unit.sv */
// Monochrome page framebuffer with a byte blitter and direct byte access.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | action, src_column, src_band, data, addr
//   out     | source    | out_valid_o/out_stall_i | read_data
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A blit makes up to two read-modify-write passes of the single-port frame memory,
// one read and one write each.
// After reset a clearing pass zeroes all STORE_BYTES (1024) bytes of the memory, one byte
// a cycle; input transactions are stalled meanwhile, configuration is taken.
// A read result sits in an output register, so the next transaction can be accepted
// while the result is stalled; a second read waits until the register is free.
`default_nettype none

module mono_page_framebuffer_blitter_unit
  import mpfb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input transactions
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [1:0]            action_i,
  input  wire logic [6:0]            src_column_i,
  input  wire logic [2:0]            src_band_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic [9:0]            fb_address_i,
  // Read results
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [7:0]            read_data_o,
  // Configuration writes
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q;
  logic [6:0]        dest_x_q;
  logic [5:0]        dest_y_q;
  logic [7:0]        blit_width_q;
  logic [6:0]        blit_height_q;

  logic              out_valid_q;
  logic [7:0]        read_data_q;

  // Blit work registers: byte masks, data and addresses for both pages.
  logic [7:0]        m0_q, d0_q, m1_q, d1_q;
  logic [ADDR_W-1:0] a0_q, a1_q;
  logic              do1_q;
  logic              rd_zero_q;

  logic              accept;
  logic              fb_in_range;
  logic [ADDR_W-1:0] fb_idx;

  // Frame memory, single port, registered read.
  logic [7:0]        mem_q [STORE_BYTES];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  // Blit setup signals.
  logic [6:0]        base_row;
  logic [7:0]        dst_col;
  logic              col_ok;
  logic [7:0]        pix_mask;
  logic [15:0]       win_mask, win_data;
  logic [3:0]        page0;
  logic [4:0]        page1;
  logic [15:0]       addr0_w, addr1_w;
  logic              load_out;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign fb_in_range = 16'(fb_address_i) < 16'(STORE_BYTES);
  assign fb_idx      = ADDR_W'(fb_address_i);

  // Blit geometry: one window of sixteen rows spanning two pages.
  always_comb begin
    base_row = 7'(dest_y_q) + {1'b0, src_band_i, 3'b000};
    dst_col  = {1'b0, dest_x_q} + {1'b0, src_column_i};
    col_ok   = ({1'b0, src_column_i} < blit_width_q) &&
               (9'(dst_col) < 9'(SCREEN_COLUMNS));
    for (int k = 0; k < 8; k++) begin
      pix_mask[7-k] = col_ok &&
                      ({1'b0, src_band_i, 3'(k)} < blit_height_q) &&
                      (8'(base_row + 7'(k)) < 8'(SCREEN_ROWS));
    end
    win_mask = {pix_mask, 8'h00} >> dest_y_q[2:0];
    win_data = {~data_byte_i, 8'h00} >> dest_y_q[2:0];
    page0    = base_row[6:3];
    page1    = {1'b0, page0} + 5'd1;
    addr0_w  = 16'(page0) * 16'(SCREEN_COLUMNS) + 16'(dst_col);
    addr1_w  = 16'(page1) * 16'(SCREEN_COLUMNS) + 16'(dst_col);
  end

  // Read result may move to the output register once it is free.
  assign load_out = (state_q == ST_RDW) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_READ: state_d = ST_RDW;
            ACT_BLIT: begin
              if (|win_mask[15:8])     state_d = ST_BRD0;
              else if (|win_mask[7:0]) state_d = ST_BRD1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RDW:  if (load_out) state_d = ST_IDLE;
      ST_BRD0: state_d = ST_BWR0;
      ST_BWR0: state_d = do1_q ? ST_BRD1 : ST_IDLE;
      ST_BRD1: state_d = ST_BWR1;
      ST_BWR1: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = fb_idx;
    mem_wdata = data_byte_i;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = 8'h00;
      end
      ST_IDLE: begin
        mem_we = accept && (action_i == ACT_WRITE) && fb_in_range;
        mem_re = accept && (action_i == ACT_READ) && fb_in_range;
      end
      ST_BRD0: begin
        mem_re   = 1'b1;
        mem_addr = a0_q;
      end
      ST_BWR0: begin
        mem_we    = 1'b1;
        mem_addr  = a0_q;
        mem_wdata = (rdata_q & ~m0_q) | (d0_q & m0_q);
      end
      ST_BRD1: begin
        mem_re   = 1'b1;
        mem_addr = a1_q;
      end
      ST_BWR1: begin
        mem_we    = 1'b1;
        mem_addr  = a1_q;
        mem_wdata = (rdata_q & ~m1_q) | (d1_q & m1_q);
      end
      default: ;
    endcase
  end

  // Frame memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      dest_x_q      <= '0;
      dest_y_q      <= '0;
      blit_width_q  <= BLIT_WIDTH_RST;
      blit_height_q <= BLIT_HEIGHT_RST;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DEST_X:      dest_x_q      <= cfg_data_i[6:0];
          CFG_DEST_Y:      dest_y_q      <= cfg_data_i[5:0];
          CFG_BLIT_WIDTH:  blit_width_q  <= cfg_data_i[7:0];
          CFG_BLIT_HEIGHT: blit_height_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers for the transaction in progress and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m0_q      <= win_mask[15:8];
      d0_q      <= win_data[15:8];
      m1_q      <= win_mask[7:0];
      d1_q      <= win_data[7:0];
      do1_q     <= |win_mask[7:0];
      a0_q      <= ADDR_W'(addr0_w);
      a1_q      <= ADDR_W'(addr1_w);
      rd_zero_q <= !fb_in_range;
    end
    if (load_out) read_data_q <= rd_zero_q ? 8'h00 : rdata_q;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // A page write only happens when some pixel of that page is drawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BWR0) |-> (m0_q != 8'h00))
    else $error("first page write with empty mask");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BWR1) |-> (m1_q != 8'h00))
    else $error("second page write with empty mask");

  // The first page read of a blit pass is followed by its write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BRD0) |=> (state_q == ST_BWR0))
    else $error("blit read not followed by its write");

  // A new result only appears after a read transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RDW))
    else $error("result without a read transaction");

endmodule

`default_nettype wire
